@@ rtl/sal_pkg.sv @@
// ----------------------------------------------------------------------------
// sal_pkg: shared constants for the sorted array list
// Capacity, derived widths, operation codes and status codes.
// ----------------------------------------------------------------------------
package sal_pkg;

    // list storage
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // fixed field widths
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic [KIND_W-1:0] K_INS_HEAD   = 3'd0;
    localparam logic [KIND_W-1:0] K_INS_SORTED = 3'd1;
    localparam logic [KIND_W-1:0] K_REM_FIRST  = 3'd2;
    localparam logic [KIND_W-1:0] K_REM_ALL    = 3'd3;
    localparam logic [KIND_W-1:0] K_SEARCH     = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

endpackage

@@ rtl/sorted_array_list.sv @@
// ----------------------------------------------------------------------------
// sorted_array_list: bounded list of signed values with five operations
// Sequence: after a request is accepted, the count entries held are read,
// one entry per cycle, through the single registered read port of the entry
// memory; the finish state then loads the result register once it is free.
// A new request is taken only once the sequencer is back in idle; the result
// register frees the request side while a finished result waits.
// Reset: synchronous active-low; clears the count, sequencer and result valid.
// ----------------------------------------------------------------------------
module sorted_array_list (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [sal_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [sal_pkg::VALUE_W-1:0]  i_value,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sal_pkg::STATUS_W-1:0]        o_status,
    output logic                                o_found,
    output logic [sal_pkg::COUNT_W-1:0]         o_count,
    output logic                                o_is_full,
    output logic                                o_is_empty
);

    localparam int CNT_W = sal_pkg::CNT_W;
    localparam int IDX_W = sal_pkg::IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    t_state                             r_state;
    logic [CNT_W-1:0]                   r_count;
    logic [sal_pkg::KIND_W-1:0]         r_kind;
    logic signed [sal_pkg::VALUE_W-1:0] r_value;
    logic                               r_full;
    logic [CNT_W-1:0]                   r_left;
    logic [IDX_W-1:0]                   r_rd_ptr;
    logic                               r_dv;
    logic [IDX_W-1:0]                   r_d_idx;
    logic signed [sal_pkg::VALUE_W-1:0] r_rdata;
    logic                               r_hit;
    logic                               r_moving;
    logic [IDX_W-1:0]                   r_pos;
    logic [CNT_W-1:0]                   r_wr_ptr;
    logic                               r_o_valid;
    logic [sal_pkg::STATUS_W-1:0]       r_o_status;
    logic                               r_o_found;
    logic [CNT_W-1:0]                   r_o_count;

    logic signed [sal_pkg::VALUE_W-1:0] mem [sal_pkg::CAPACITY];

    logic                               w_accept;
    logic                               w_is_ins;
    logic                               w_is_rem;
    logic                               w_desc;
    logic                               w_match;
    logic                               w_skip;
    logic                               w_rd_en;
    logic                               w_fin_go;
    logic                               w_we;
    logic [IDX_W-1:0]                   w_waddr;
    logic signed [sal_pkg::VALUE_W-1:0] w_wdata;
    logic [sal_pkg::STATUS_W-1:0]       w_status;
    logic [CNT_W-1:0]                   w_new_count;

    // decode the held operation and the direction of the incoming one
    assign w_accept = i_valid && o_ready;
    assign w_is_ins = (r_kind == sal_pkg::K_INS_HEAD) || (r_kind == sal_pkg::K_INS_SORTED);
    assign w_is_rem = (r_kind == sal_pkg::K_REM_FIRST) || (r_kind == sal_pkg::K_REM_ALL);
    assign w_desc   = (i_kind == sal_pkg::K_INS_HEAD) || (i_kind == sal_pkg::K_INS_SORTED);

    // shared compare on the entry just read
    assign w_match  = (r_rdata == r_value);
    assign w_skip   = w_match && ((r_kind == sal_pkg::K_REM_ALL) || !r_hit);
    assign w_rd_en  = (r_state == S_RUN) && (r_left != '0);
    assign w_fin_go = !r_o_valid || i_ready;

    // pick the single memory write of this cycle
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = r_rdata;
        unique case (r_state)
            S_RUN: begin
                if (r_dv && w_is_ins && !r_full) begin
                    if ((r_kind == sal_pkg::K_INS_HEAD) || (r_moving && (r_rdata > r_value))) begin
                        w_we    = 1'b1;
                        w_waddr = r_d_idx + IDX_W'(1);
                    end
                end else if (r_dv && w_is_rem && !w_skip) begin
                    w_we    = 1'b1;
                    w_waddr = r_wr_ptr[IDX_W-1:0];
                end
            end
            S_FIN: begin
                if (w_fin_go && w_is_ins && !r_full) begin
                    w_we    = 1'b1;
                    w_waddr = r_pos;
                    w_wdata = r_value;
                end
            end
            default: begin
            end
        endcase
    end

    // work out the result of the finished pass
    always_comb begin
        w_new_count = r_count;
        w_status    = sal_pkg::ST_DONE;
        if (w_is_ins) begin
            if (r_full) begin
                w_status = sal_pkg::ST_FULL;
            end else begin
                w_new_count = r_count + CNT_W'(1);
            end
        end else if (w_is_rem) begin
            if (r_hit) begin
                w_new_count = r_wr_ptr;
            end else begin
                w_status = sal_pkg::ST_MISSING;
            end
        end else if (r_kind == sal_pkg::K_SEARCH) begin
            w_status = r_hit ? sal_pkg::ST_DONE : sal_pkg::ST_MISSING;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rdata <= mem[r_rd_ptr];
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    // latch the request and set up the scan
                    if (w_accept) begin
                        r_kind   <= i_kind;
                        r_value  <= i_value;
                        r_full   <= (r_count == CNT_W'(sal_pkg::CAPACITY));
                        r_left   <= r_count;
                        r_rd_ptr <= w_desc ? IDX_W'(r_count - CNT_W'(1)) : '0;
                        r_dv     <= 1'b0;
                        r_hit    <= 1'b0;
                        r_moving <= 1'b1;
                        r_pos    <= '0;
                        r_wr_ptr <= '0;
                        r_state  <= S_RUN;
                    end
                end
                S_RUN: begin
                    // advance the read pointer one entry
                    if (r_left != '0) begin
                        r_left   <= r_left - CNT_W'(1);
                        r_d_idx  <= r_rd_ptr;
                        r_dv     <= 1'b1;
                        r_rd_ptr <= (r_kind == sal_pkg::K_INS_HEAD ||
                                     r_kind == sal_pkg::K_INS_SORTED) ?
                                    r_rd_ptr - IDX_W'(1) : r_rd_ptr + IDX_W'(1);
                    end else begin
                        r_dv    <= 1'b0;
                        r_state <= S_FIN;
                    end
                    // track match, insert position and compaction pointer
                    if (r_dv) begin
                        if (w_match) begin
                            r_hit <= 1'b1;
                        end
                        if ((r_kind == sal_pkg::K_INS_SORTED) && r_moving &&
                            !(r_rdata > r_value)) begin
                            r_moving <= 1'b0;
                            r_pos    <= r_d_idx + IDX_W'(1);
                        end
                        if (w_is_rem && !w_skip) begin
                            r_wr_ptr <= r_wr_ptr + CNT_W'(1);
                        end
                    end
                end
                S_FIN: begin
                    // hold until the result register is free
                    if (w_fin_go) begin
                        r_count    <= w_new_count;
                        r_o_valid  <= 1'b1;
                        r_o_status <= w_status;
                        r_o_found  <= r_hit;
                        r_o_count  <= w_new_count;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // drive the ports
    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_o_valid;
    assign o_status   = r_o_status;
    assign o_found    = r_o_found;
    assign o_count    = sal_pkg::COUNT_W'(r_o_count);
    assign o_is_full  = (r_o_count == CNT_W'(sal_pkg::CAPACITY));
    assign o_is_empty = (r_o_count == '0);

    // count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(sal_pkg::CAPACITY))
        else $error("entry count above capacity");

    // count grows by at most one per request
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count > $past(r_count)) |-> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("entry count grew by more than one");

    // compaction pointer never passes the count of held entries
    a_wr_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_wr_ptr <= r_count))
        else $error("compaction pointer ahead of held entries");

    // a rejected insert only comes from a full list
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == sal_pkg::ST_FULL)) |-> o_is_full)
        else $error("full status on a list that is not full");

endmodule
